/* hdl/gdda_pkg.sv */
// Shared constants, codes and helper functions for the Gregorian date
// arithmetic core. No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package gdda_pkg;

    // Default upper bound of the supported year range
    localparam int MAX_YEAR_DEF = 9999;

    // Field widths of one input item and one result item
    localparam int OP_W     = 1;
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int OFFSET_W = 21;
    localparam int DIFF_W   = 23;
    localparam int STATUS_W = 2;
    localparam int DOY_W    = 9;

    // Input tdata layout, lowest field first
    localparam int IN_DATA_W      = 72;
    localparam int IN_YEAR_LSB    = 0;
    localparam int IN_MONTH_LSB   = IN_YEAR_LSB + YEAR_W;
    localparam int IN_DAY_LSB     = IN_MONTH_LSB + MONTH_W;
    localparam int IN_OFFSET_LSB  = IN_DAY_LSB + DAY_W;
    localparam int IN_OYEAR_LSB   = IN_OFFSET_LSB + OFFSET_W;
    localparam int IN_OMONTH_LSB  = IN_OYEAR_LSB + YEAR_W;
    localparam int IN_ODAY_LSB    = IN_OMONTH_LSB + MONTH_W;
    localparam int IN_USED_W      = IN_ODAY_LSB + DAY_W;

    // Output tdata layout, lowest field first
    localparam int OUT_DATA_W = 48;
    localparam int OUT_USED_W = YEAR_W + MONTH_W + DAY_W + DIFF_W;

    // x / 25 as (x * 41944) >> 20, exact for x below 2^15
    localparam int DIV25_MUL = 41944;
    localparam int DIV25_W   = 16;
    localparam int DIV25_SH  = 20;

    // Year estimate from a day number: ((n >> 7) * 22967) >> 16 ~ n / 365.2425
    localparam int EST_PRE = 7;
    localparam int EST_MUL = 22967;
    localparam int EST_W   = 15;
    localparam int EST_SH  = 16;

    localparam int DAYS_PER_YEAR = 365;
    localparam int MONTHS        = 12;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_DATE = 2'd1,
        ST_RANGE    = 2'd2
    } t_status;

    typedef enum logic [OP_W-1:0] {
        OP_ADD  = 1'b0,
        OP_DIFF = 1'b1
    } t_op;

    // Width of a signed day number for a given year bound, at least 22 bits
    // so that the 21-bit offset can be added without overflow
    function automatic int day_num_width(input int max_year);
        int w;
        w = $clog2(366 * max_year + 1);
        if (w < OFFSET_W) begin
            w = OFFSET_W;
        end
        return w + 1;
    endfunction

    // Days from 0001-01-01 to 1 January of year y; elaboration use only
    function automatic longint days_before_year_c(input longint y);
        longint p;
        p = y - 1;
        return 365 * p + p / 4 - p / 100 + p / 400;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
            4'd2:                                        len = leap ? 5'd29 : 5'd28;
            default:                                     len = 5'd0;
        endcase
        return len;
    endfunction

    // Days in the months before m of a common year
    function automatic logic [DOY_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] s;
        case (m)
            4'd2:    s = 9'd31;
            4'd3:    s = 9'd59;
            4'd4:    s = 9'd90;
            4'd5:    s = 9'd120;
            4'd6:    s = 9'd151;
            4'd7:    s = 9'd181;
            4'd8:    s = 9'd212;
            4'd9:    s = 9'd243;
            4'd10:   s = 9'd273;
            4'd11:   s = 9'd304;
            4'd12:   s = 9'd334;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

    // Zero-based day of year
    function automatic logic [DOY_W-1:0] day_of_year(input logic [MONTH_W-1:0] m,
                                                     input logic [DAY_W-1:0] d,
                                                     input logic leap);
        logic [DOY_W-1:0] s;
        s = days_before_month(m) + DOY_W'(leap && (m > 4'd2)) + DOY_W'(d) - 9'd1;
        return s;
    endfunction

endpackage

/* hdl/gdda_year_unit.sv */
// Shared year unit: days before 1 January of a year and its leap flag,
// two register stages. Depends on gdda_pkg.
`timescale 1ns / 1ps

module gdda_year_unit #(
    parameter int  MAX_YEAR = gdda_pkg::MAX_YEAR_DEF,
    localparam int YW       = $clog2(MAX_YEAR + 1),
    localparam int NW       = gdda_pkg::day_num_width(MAX_YEAR)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [YW-1:0] i_year,
    output logic          o_done,
    output logic          o_leap,
    output logic [NW-1:0] o_dby
);
    import gdda_pkg::*;

    localparam int PW = YW - 2 + DIV25_W;
    localparam int QW = PW - DIV25_SH;      // width of p / 100

    logic [YW-1:0] p;
    logic [PW-1:0] q25_prod;

    logic          r_v1;
    logic          r_v2;
    logic [YW-1:0] r_p;
    logic [NW-1:0] r_p365;
    logic [YW-3:0] r_q4;
    logic [QW-1:0] r_q100;
    logic          r_leap;
    logic [NW-1:0] r_dby;

    logic          m100;
    logic          m400;

    assign p        = i_year - 1'b1;
    // (p/4)/25 = p/100
    assign q25_prod = PW'(p[YW-1:2]) * PW'(DIV25_MUL);

    // stage 1: scaled year and quotients
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_p    <= p;
            r_p365 <= NW'(int'(p) * DAYS_PER_YEAR);
            r_q4   <= p[YW-1:2];
            r_q100 <= q25_prod[PW-1:DIV25_SH];
        end
    end

    // y = p + 1 is a multiple of 100 (400) when p mod 100 (400) is 99 (399)
    assign m100 = (int'(r_p) - int'(r_q100) * 100) == 99;
    assign m400 = (int'(r_p) - int'(r_q100 >> 2) * 400) == 399;

    // stage 2: sum and leap rule
    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_dby  <= r_p365 + NW'(r_q4) - NW'(r_q100) + NW'(r_q100 >> 2);
            r_leap <= ((r_p[1:0] == 2'b11) && !m100) || m400;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
        end
    end

    assign o_done = r_v2;
    assign o_leap = r_leap;
    assign o_dby  = r_dby;

endmodule

/* hdl/gregorian_date_day_arithmetic_core.sv */
// Top level of the Gregorian date arithmetic core: stream ports, sequencer
// and output register. Depends on gdda_pkg and gdda_year_unit.
`timescale 1ns / 1ps

// Usage
//   Slave stream takes one request item: tuser[0] is the operation
//   (0 add a signed day offset to a date, 1 difference first minus second
//   date), tdata carries the two dates and the offset. Master stream gives
//   one result item per request: tdata the result date and day difference,
//   tuser the status (ok, invalid input date, result year out of range).
//   One item is worked on at a time; tready is low from acceptance until
//   the result has moved into the output register.
//   The time from acceptance to result tvalid depends on the operation. A
//   difference, an addition with an invalid date and an addition whose
//   result falls outside the year range end without the year search and
//   month walk. Any other addition also waits on the shared year unit (one
//   pass for each year tried while the year search corrects its estimate,
//   usually one or two tries) and on the month walk, which passes the
//   months one by one.
//   The output register frees the sequencer: a new request is taken while
//   a result still waits; if the receiver stalls, the next result waits in
//   the sequencer and tready stays low until the output register empties.
//   Reset (synchronous, active low) returns to idle and drops tvalid.
module gregorian_date_day_arithmetic_core #(
    parameter int MAX_YEAR = gdda_pkg::MAX_YEAR_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // year[13:0], month[17:14], day[22:18], offset_days[43:23],
    // other_year[57:44], other_month[61:58], other_day[66:62], zero pad
    input  logic [gdda_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // op[0]
    input  logic [gdda_pkg::OP_W-1:0]       i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // res_year[13:0], res_month[17:14], res_day[22:18],
    // day_difference[45:23], zero pad
    output logic [gdda_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    // status[1:0]
    output logic [gdda_pkg::STATUS_W-1:0]   o_m_axis_tuser
);
    import gdda_pkg::*;

    localparam int YW   = $clog2(MAX_YEAR + 1);
    localparam int NW   = day_num_width(MAX_YEAR);
    localparam int EW   = (NW - 1 - EST_PRE) + EST_W;   // estimate product
    localparam int ESTW = EW - EST_SH;
    localparam logic signed [NW-1:0] LAST_DAY =
        NW'(days_before_year_c(longint'(MAX_YEAR) + 1) - 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_WAIT1 = 10'b00_0000_0010,   // first date through year unit
        S_WAIT2 = 10'b00_0000_0100,   // second date through year unit
        S_DIFF  = 10'b00_0000_1000,
        S_OFFS  = 10'b00_0001_0000,
        S_RANGE = 10'b00_0010_0000,
        S_EST   = 10'b00_0100_0000,
        S_YWAIT = 10'b00_1000_0000,   // year search
        S_MONTH = 10'b01_0000_0000,   // month walk
        S_OUT   = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;

    // latched request
    logic                       r_op,     n_op;
    logic [YEAR_W-1:0]          r_y1,     n_y1;
    logic [MONTH_W-1:0]         r_m1,     n_m1;
    logic [DAY_W-1:0]           r_d1,     n_d1;
    logic signed [OFFSET_W-1:0] r_off,    n_off;
    logic [YEAR_W-1:0]          r_y2,     n_y2;
    logic [MONTH_W-1:0]         r_m2,     n_m2;
    logic [DAY_W-1:0]           r_d2,     n_d2;

    // working values
    logic signed [NW-1:0]       r_n,      n_n;
    logic [NW-1:0]              r_n2,     n_n2;
    logic                       r_bad,    n_bad;
    logic [EW-1:0]              r_prod,   n_prod;
    logic [YW-1:0]              r_yy,     n_yy;
    logic                       r_leap,   n_leap;
    logic [DOY_W-1:0]           r_rem,    n_rem;
    logic [MONTH_W-1:0]         r_mm,     n_mm;

    // finished result
    logic [YEAR_W-1:0]          r_ry,     n_ry;
    logic [MONTH_W-1:0]         r_rm,     n_rm;
    logic [DAY_W-1:0]           r_rd,     n_rd;
    logic signed [NW-1:0]       r_diff,   n_diff;
    t_status                    r_status, n_status;

    // output register
    logic                       r_out_valid;
    logic [OUT_DATA_W-1:0]      r_out_data;
    logic [STATUS_W-1:0]        r_out_user;

    // year unit
    logic                       u_start;
    logic [YW-1:0]              u_year;
    logic                       u_done;
    logic                       u_leap;
    logic [NW-1:0]              u_dby;

    logic                       s_accept;
    logic                       out_free;
    logic                       date_ok;
    logic [NW-1:0]              dby_next;
    logic [ESTW-1:0]            est;
    logic [DAY_W-1:0]           mlen;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign dby_next        = u_dby + NW'(DAYS_PER_YEAR) + NW'(u_leap);
    assign est             = r_prod[EW-1:EST_SH];
    assign mlen            = month_len(r_mm, r_leap);

    gdda_year_unit #(
        .MAX_YEAR (MAX_YEAR)
    ) u_year_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (u_start),
        .i_year  (u_year),
        .o_done  (u_done),
        .o_leap  (u_leap),
        .o_dby   (u_dby)
    );

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_y1     = r_y1;
        n_m1     = r_m1;
        n_d1     = r_d1;
        n_off    = r_off;
        n_y2     = r_y2;
        n_m2     = r_m2;
        n_d2     = r_d2;
        n_n      = r_n;
        n_n2     = r_n2;
        n_bad    = r_bad;
        n_prod   = r_prod;
        n_yy     = r_yy;
        n_leap   = r_leap;
        n_rem    = r_rem;
        n_mm     = r_mm;
        n_ry     = r_ry;
        n_rm     = r_rm;
        n_rd     = r_rd;
        n_diff   = r_diff;
        n_status = r_status;
        u_start  = 1'b0;
        u_year   = r_yy;
        date_ok  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_op     = i_s_axis_tuser[0];
                    n_y1     = i_s_axis_tdata[IN_YEAR_LSB +: YEAR_W];
                    n_m1     = i_s_axis_tdata[IN_MONTH_LSB +: MONTH_W];
                    n_d1     = i_s_axis_tdata[IN_DAY_LSB +: DAY_W];
                    n_off    = i_s_axis_tdata[IN_OFFSET_LSB +: OFFSET_W];
                    n_y2     = i_s_axis_tdata[IN_OYEAR_LSB +: YEAR_W];
                    n_m2     = i_s_axis_tdata[IN_OMONTH_LSB +: MONTH_W];
                    n_d2     = i_s_axis_tdata[IN_ODAY_LSB +: DAY_W];
                    n_ry     = '0;
                    n_rm     = '0;
                    n_rd     = '0;
                    n_diff   = '0;
                    n_status = ST_OK;
                    u_start  = 1'b1;
                    u_year   = YW'(i_s_axis_tdata[IN_YEAR_LSB +: YEAR_W]);
                    n_state  = S_WAIT1;
                end
            end

            S_WAIT1: begin
                if (u_done) begin
                    date_ok = (r_y1 != '0) && (32'(r_y1) <= MAX_YEAR)
                              && (r_m1 != '0) && (r_m1 <= MONTH_W'(MONTHS))
                              && (r_d1 != '0) && (r_d1 <= month_len(r_m1, u_leap));
                    n_bad = !date_ok;
                    n_n   = u_dby + NW'(day_of_year(r_m1, r_d1, u_leap));
                    if (r_op == OP_DIFF) begin
                        u_start = 1'b1;
                        u_year  = YW'(r_y2);
                        n_state = S_WAIT2;
                    end else begin
                        n_state = S_OFFS;
                    end
                end
            end

            S_WAIT2: begin
                if (u_done) begin
                    date_ok = (r_y2 != '0) && (32'(r_y2) <= MAX_YEAR)
                              && (r_m2 != '0) && (r_m2 <= MONTH_W'(MONTHS))
                              && (r_d2 != '0) && (r_d2 <= month_len(r_m2, u_leap));
                    n_bad   = r_bad || !date_ok;
                    n_n2    = u_dby + NW'(day_of_year(r_m2, r_d2, u_leap));
                    n_state = S_DIFF;
                end
            end

            S_DIFF: begin
                if (r_bad) begin
                    n_status = ST_BAD_DATE;
                end else begin
                    n_diff = r_n - $signed(r_n2);
                end
                n_state = S_OUT;
            end

            S_OFFS: begin
                if (r_bad) begin
                    n_status = ST_BAD_DATE;
                    n_state  = S_OUT;
                end else begin
                    n_n     = r_n + NW'(r_off);
                    n_state = S_RANGE;
                end
            end

            S_RANGE: begin
                if ((r_n < 0) || (r_n > LAST_DAY)) begin
                    n_status = ST_RANGE;
                    n_state  = S_OUT;
                end else begin
                    n_prod  = EW'(r_n[NW-2:EST_PRE]) * EW'(EST_MUL);
                    n_state = S_EST;
                end
            end

            S_EST: begin
                // first guess at the year; the search corrects it
                if (est >= ESTW'(MAX_YEAR)) begin
                    u_year = YW'(MAX_YEAR);
                end else begin
                    u_year = YW'(est + 1'b1);
                end
                n_yy    = u_year;
                u_start = 1'b1;
                n_state = S_YWAIT;
            end

            S_YWAIT: begin
                if (u_done) begin
                    if (u_dby > $unsigned(r_n)) begin
                        u_year  = r_yy - 1'b1;
                        n_yy    = u_year;
                        u_start = 1'b1;
                    end else if (dby_next <= $unsigned(r_n)) begin
                        u_year  = r_yy + 1'b1;
                        n_yy    = u_year;
                        u_start = 1'b1;
                    end else begin
                        n_rem   = DOY_W'($unsigned(r_n) - u_dby);
                        n_leap  = u_leap;
                        n_mm    = MONTH_W'(1);
                        n_state = S_MONTH;
                    end
                end
            end

            S_MONTH: begin
                if ((r_mm != MONTH_W'(MONTHS)) && (r_rem >= DOY_W'(mlen))) begin
                    n_rem = r_rem - DOY_W'(mlen);
                    n_mm  = r_mm + 1'b1;
                end else begin
                    n_ry    = YEAR_W'(r_yy);
                    n_rm    = r_mm;
                    n_rd    = DAY_W'(r_rem + 1'b1);
                    n_state = S_OUT;
                end
            end

            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_y1     <= n_y1;
        r_m1     <= n_m1;
        r_d1     <= n_d1;
        r_off    <= n_off;
        r_y2     <= n_y2;
        r_m2     <= n_m2;
        r_d2     <= n_d2;
        r_n      <= n_n;
        r_n2     <= n_n2;
        r_bad    <= n_bad;
        r_prod   <= n_prod;
        r_yy     <= n_yy;
        r_leap   <= n_leap;
        r_rem    <= n_rem;
        r_mm     <= n_mm;
        r_ry     <= n_ry;
        r_rm     <= n_rm;
        r_rd     <= n_rd;
        r_diff   <= n_diff;
        r_status <= n_status;
    end

    // output register: loads the finished item once the slot is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_OUT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && out_free) begin
            r_out_data <= {(OUT_DATA_W - OUT_USED_W)'(0), DIFF_W'(r_diff), r_rd, r_rm, r_ry};
            r_out_user <= r_status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule
